@@ rtl/proximity_follow_steering_unit_assert.svh @@
// Assertion macros for the steering unit top-level source.
`ifndef PROXIMITY_FOLLOW_STEERING_UNIT_ASSERT_SVH
`define PROXIMITY_FOLLOW_STEERING_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define PFS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define PFS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define PFS_ASSERT(label, clk, rst_n, prop, msg)
`define PFS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/pfs_pkg.sv @@
package pfs_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SENSOR_W     = 13;
    localparam int IDX_W        = 3;
    localparam int SPEED_W      = 12;
    localparam int LIMIT_W      = 11;
    localparam int THR_W        = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam int IN_TDATA_W   = ((SENSOR_COUNT * SENSOR_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * SPEED_W + 2 * IDX_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_THRESHOLD  = 2'd2;

    localparam logic [LIMIT_W-1:0] RESET_SPEED_LIMIT    = 11'd500;
    localparam logic [THR_W-1:0]   RESET_NEAR_THRESHOLD = 12'd2500;
    localparam logic [THR_W-1:0]   RESET_FAR_THRESHOLD  = 12'd2000;

    localparam logic [IDX_W-1:0] SENSOR_FRONT_RIGHT = 3'd0;
    localparam logic [IDX_W-1:0] SENSOR_FRONT_LEFT  = 3'd7;

    typedef logic signed [SENSOR_W-1:0] t_sensor;
    typedef t_sensor t_sensor_arr [SENSOR_COUNT];
    typedef logic signed [SPEED_W-1:0] t_speed;

    typedef struct packed {
        logic is_first;
        logic is_second;
    } t_lane_flags;

    typedef t_lane_flags t_lane_arr [SENSOR_COUNT];

    typedef struct packed {
        logic [LIMIT_W-1:0] speed_limit;
        logic [THR_W-1:0]   near_threshold;
        logic [THR_W-1:0]   far_threshold;
    } t_cfg;

endpackage

@@ rtl/pfs_lane.sv @@
module pfs_lane
    import pfs_pkg::*;
#(
    parameter int unsigned LANE = 0
) (
    input  t_sensor_arr i_sensors,
    output t_lane_flags o_flags
);

    logic [SENSOR_COUNT-1:0] w_beat;

    // A sensor beats this lane when stronger, or equal and earlier.
    always_comb begin
        for (int j = 0; j < SENSOR_COUNT; j++) begin
            if (j == LANE) begin
                w_beat[j] = 1'b0;
            end else if (j < LANE) begin
                w_beat[j] = (i_sensors[j] >= i_sensors[LANE]);
            end else begin
                w_beat[j] = (i_sensors[j] > i_sensors[LANE]);
            end
        end
    end

    assign o_flags.is_first  = ~|w_beat;
    assign o_flags.is_second = $onehot(w_beat);

endmodule

@@ rtl/pfs_merge.sv @@
module pfs_merge
    import pfs_pkg::*;
(
    input  t_sensor_arr       i_sensors,
    input  t_lane_arr         i_flags,
    output logic [IDX_W-1:0]  o_first,
    output logic [IDX_W-1:0]  o_second,
    output t_sensor           o_max
);

    // Exactly one lane raises each flag, so an OR over the lanes encodes it.
    always_comb begin
        o_first  = '0;
        o_second = '0;
        o_max    = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (i_flags[i].is_first) begin
                o_first = o_first | IDX_W'(i);
                o_max   = o_max | i_sensors[i];
            end
            if (i_flags[i].is_second) begin
                o_second = o_second | IDX_W'(i);
            end
        end
    end

endmodule

@@ rtl/pfs_steer.sv @@
module pfs_steer
    import pfs_pkg::*;
(
    input  t_cfg              i_cfg,
    input  logic [IDX_W-1:0]  i_first,
    input  logic [IDX_W-1:0]  i_second,
    input  t_sensor           i_max,
    output t_speed            o_left,
    output t_speed            o_right
);

    logic signed [SENSOR_W:0] w_max_ext;
    logic signed [SENSOR_W:0] w_far_ext;
    logic signed [SENSOR_W:0] w_near_ext;
    logic   w_gt_far;
    logic   w_lt_far;
    logic   w_gt_near;
    logic   w_both_front;
    t_speed w_lim;
    t_speed w_neg_lim;
    t_speed w_lim_half;
    t_speed w_neg_half;
    t_speed w_lim_qtr;
    t_speed w_a;
    t_speed w_b;
    t_speed w_a_half;
    t_speed w_b_half;

    assign w_max_ext  = (SENSOR_W + 1)'(i_max);
    assign w_far_ext  = $signed({2'b00, i_cfg.far_threshold});
    assign w_near_ext = $signed({2'b00, i_cfg.near_threshold});
    assign w_gt_far   = (w_max_ext > w_far_ext);
    assign w_lt_far   = (w_max_ext < w_far_ext);
    assign w_gt_near  = (w_max_ext > w_near_ext);

    assign w_lim      = $signed({1'b0, i_cfg.speed_limit});
    assign w_neg_lim  = -w_lim;
    assign w_lim_half = $signed({2'b00, i_cfg.speed_limit[LIMIT_W-1:1]});
    assign w_neg_half = -w_lim_half;
    assign w_lim_qtr  = $signed({3'b000, i_cfg.speed_limit[LIMIT_W-1:2]});

    // Turn profile (a, b) and its halves, truncated toward zero.
    always_comb begin
        if (w_gt_far) begin
            w_a      = w_lim;
            w_b      = w_neg_lim;
            w_a_half = w_lim_half;
            w_b_half = w_neg_half;
        end else if (w_lt_far) begin
            w_a      = w_lim;
            w_b      = w_lim_half;
            w_a_half = w_lim_half;
            w_b_half = w_lim_qtr;
        end else begin
            w_a      = '0;
            w_b      = '0;
            w_a_half = '0;
            w_b_half = '0;
        end
    end

    assign w_both_front =
        ((i_first == SENSOR_FRONT_RIGHT) && (i_second == SENSOR_FRONT_LEFT)) ||
        ((i_first == SENSOR_FRONT_LEFT) && (i_second == SENSOR_FRONT_RIGHT));

    always_comb begin
        if (w_both_front) begin
            // Hold distance: back off, approach or stop.
            if (w_gt_near) begin
                o_left  = w_neg_lim;
                o_right = w_neg_lim;
            end else if (w_lt_far) begin
                o_left  = w_lim;
                o_right = w_lim;
            end else begin
                o_left  = '0;
                o_right = '0;
            end
        end else if (i_first == SENSOR_FRONT_RIGHT) begin
            o_left  = w_a_half;
            o_right = w_b_half;
        end else if (i_first == SENSOR_FRONT_LEFT) begin
            o_left  = w_b_half;
            o_right = w_a_half;
        end else if (i_first inside {[3'd1:3'd3]}) begin
            o_left  = w_a;
            o_right = w_b;
        end else begin
            o_left  = w_b;
            o_right = w_a;
        end
    end

endmodule

@@ rtl/proximity_follow_steering_unit.sv @@
// Proximity-follow steering unit.
// s_axis carries one frame of eight 13-bit signed proximity readings per beat,
// sensor 0 (front right) in the low bits up to sensor 7 (front left).
// m_axis returns one steering beat per frame: left and right wheel speeds
// (12-bit signed) and the indexes of the strongest and second strongest sensor.
// The cfg channel writes speed_limit (0), near_threshold (1) and
// far_threshold (2); o_cfg_ready is always high, other indexes are dropped.
// Write the registers only while no frame is in flight.
// Two register stages: the eight rank lanes and the merge feed a stage
// register, then the speed logic feeds the output register, which drives
// m_axis. Throughput is one frame per cycle while m_axis does not stall.
// When m_axis stalls, the result holds in the output register and one more
// frame may still enter the lane stage register; s_axis_tready drops once
// both are full. Synchronous reset empties both stages and loads the
// register defaults 500, 2500 and 2000.
`include "proximity_follow_steering_unit_assert.svh"

module proximity_follow_steering_unit
    import pfs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sensor_0 .. sensor_7, 13 bits each, from the low bits up
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // left_speed[11:0], right_speed[23:12], nearest_sensor[26:24],
    // runner_up_sensor[29:27], zero[31:30]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    t_sensor_arr w_sensors;
    t_lane_arr   w_flags;
    logic [IDX_W-1:0] w_first;
    logic [IDX_W-1:0] w_second;
    t_sensor          w_max;
    logic [SENSOR_COUNT-1:0] w_first_vec;
    logic [SENSOR_COUNT-1:0] w_second_vec;

    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_first;
    logic [IDX_W-1:0] r_s1_second;
    t_sensor          r_s1_max;

    t_speed w_left;
    t_speed w_right;

    logic             r_out_valid;
    t_speed           r_out_left;
    t_speed           r_out_right;
    logic [IDX_W-1:0] r_out_nearest;
    logic [IDX_W-1:0] r_out_runner;

    logic w_s_fire;
    logic w_adv1;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SPEED_LIMIT:    n_cfg.speed_limit    = i_cfg_data[LIMIT_W-1:0];
                REG_NEAR_THRESHOLD: n_cfg.near_threshold = i_cfg_data[THR_W-1:0];
                REG_FAR_THRESHOLD:  n_cfg.far_threshold  = i_cfg_data[THR_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit    <= RESET_SPEED_LIMIT;
            r_cfg.near_threshold <= RESET_NEAR_THRESHOLD;
            r_cfg.far_threshold  <= RESET_FAR_THRESHOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Rank lanes, one per sensor
    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        assign w_sensors[g]    = s_axis_tdata[g*SENSOR_W +: SENSOR_W];
        assign w_first_vec[g]  = w_flags[g].is_first;
        assign w_second_vec[g] = w_flags[g].is_second;

        pfs_lane #(
            .LANE(g)
        ) u_lane (
            .i_sensors(w_sensors),
            .o_flags  (w_flags[g])
        );
    end

    pfs_merge u_merge (
        .i_sensors(w_sensors),
        .i_flags  (w_flags),
        .o_first  (w_first),
        .o_second (w_second),
        .o_max    (w_max)
    );

    // Pipeline control: a stage advances when the one after it is free.
    assign w_adv1        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || w_adv1;
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_s1_first  <= w_first;
            r_s1_second <= w_second;
            r_s1_max    <= w_max;
        end
    end

    pfs_steer u_steer (
        .i_cfg   (r_cfg),
        .i_first (r_s1_first),
        .i_second(r_s1_second),
        .i_max   (r_s1_max),
        .o_left  (w_left),
        .o_right (w_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv1) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && r_s1_valid) begin
            r_out_left    <= w_left;
            r_out_right   <= w_right;
            r_out_nearest <= r_s1_first;
            r_out_runner  <= r_s1_second;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), r_out_runner, r_out_nearest,
                            r_out_right, r_out_left};

    `PFS_ASSERT(a_lane_ranks, i_clk, i_rst_n, s_axis_tvalid |-> ($onehot(w_first_vec) && $onehot(w_second_vec) && ((w_first_vec & w_second_vec) == '0)), "lane ranks not unique")
    `PFS_ASSERT(a_out_distinct, i_clk, i_rst_n, r_out_valid |-> (r_out_nearest != r_out_runner), "nearest equals runner-up")
    `PFS_ASSERT(a_stage_hold, i_clk, i_rst_n, (r_s1_valid && !w_adv1) |=> (r_s1_valid && $stable(r_s1_first) && $stable(r_s1_max)), "stalled stage lost its frame")
    `PFS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_out_valid && !r_s1_valid), "pipeline not empty after reset")

endmodule

@@ test/steering_checker.sv @@
module steering_checker
    import pfs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   i_cfg_valid,
    input  logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    output int                     o_mismatches,
    output int                     o_awaited
);

    logic [LIMIT_W-1:0]     limit_q;
    logic [THR_W-1:0]       near_q;
    logic [THR_W-1:0]       far_q;
    logic [OUT_TDATA_W-1:0] awaited_commands [$];

    initial begin
        o_mismatches = 0;
        o_awaited    = 0;
    end

    // Wheel command and leader indexes for one frame under the current limits
    function automatic logic [OUT_TDATA_W-1:0] steer_command(input logic [IN_TDATA_W-1:0] frame);
        t_sensor                rd [SENSOR_COUNT];
        int                     lead;
        int                     follow;
        int                     m;
        int                     lim;
        int                     near_i;
        int                     far_i;
        int                     a;
        int                     b;
        int                     left;
        int                     right;
        logic [OUT_TDATA_W-1:0] word;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            rd[i] = frame[i*SENSOR_W +: SENSOR_W];
        end
        lead   = 0;
        follow = 1;
        if (rd[1] > rd[0]) begin
            lead   = 1;
            follow = 0;
        end
        for (int i = 2; i < SENSOR_COUNT; i++) begin
            if (rd[i] > rd[lead]) begin
                follow = lead;
                lead   = i;
            end else if (rd[i] > rd[follow]) begin
                follow = i;
            end
        end

        m      = rd[lead];
        lim    = limit_q;
        near_i = near_q;
        far_i  = far_q;
        if (m > far_i) begin
            a = lim;
            b = -lim;
        end else if (m < far_i) begin
            a = lim;
            b = lim / 2;
        end else begin
            a = 0;
            b = 0;
        end

        if ((lead == SENSOR_FRONT_RIGHT && follow == SENSOR_FRONT_LEFT) ||
            (lead == SENSOR_FRONT_LEFT && follow == SENSOR_FRONT_RIGHT)) begin
            // hold distance: back off, approach, or stop
            if (m > near_i) begin
                left  = -lim;
                right = -lim;
            end else if (m < far_i) begin
                left  = lim;
                right = lim;
            end else begin
                left  = 0;
                right = 0;
            end
        end else if (lead == SENSOR_FRONT_RIGHT) begin
            left  = a / 2;
            right = b / 2;
        end else if (lead == SENSOR_FRONT_LEFT) begin
            left  = b / 2;
            right = a / 2;
        end else if (lead < 4) begin
            left  = a;
            right = b;
        end else begin
            left  = b;
            right = a;
        end

        word = '0;
        word[SPEED_W-1:0]                    = left[SPEED_W-1:0];
        word[2*SPEED_W-1:SPEED_W]            = right[SPEED_W-1:0];
        word[2*SPEED_W +: IDX_W]             = lead[IDX_W-1:0];
        word[2*SPEED_W+IDX_W +: IDX_W]       = follow[IDX_W-1:0];
        return word;
    endfunction

    task automatic compare_field(input string name, input logic [SPEED_W-1:0] want,
                                 input logic [SPEED_W-1:0] got, input bit is_signed);
        if (got !== want) begin
            if (is_signed)
                $display("%0t %s expected %0d actual %0d", $time, name,
                         $signed(want), $signed(got));
            else
                $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [OUT_TDATA_W-1:0] want;
        if (!i_rst_n) begin
            limit_q = RESET_SPEED_LIMIT;
            near_q  = RESET_NEAR_THRESHOLD;
            far_q   = RESET_FAR_THRESHOLD;
            awaited_commands.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SPEED_LIMIT:    limit_q = i_cfg_data[LIMIT_W-1:0];
                    REG_NEAR_THRESHOLD: near_q  = i_cfg_data[THR_W-1:0];
                    REG_FAR_THRESHOLD:  far_q   = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_commands.push_back(steer_command(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_commands.size() == 0) begin
                    $display("%0t steering beat with none expected, actual %h",
                             $time, m_axis_tdata);
                    o_mismatches++;
                end else begin
                    want = awaited_commands.pop_front();
                    compare_field("left_speed", want[11:0], m_axis_tdata[11:0], 1'b1);
                    compare_field("right_speed", want[23:12], m_axis_tdata[23:12], 1'b1);
                    compare_field("nearest_sensor", {9'd0, want[26:24]},
                                  {9'd0, m_axis_tdata[26:24]}, 1'b0);
                    compare_field("runner_up_sensor", {9'd0, want[29:27]},
                                  {9'd0, m_axis_tdata[29:27]}, 1'b0);
                    compare_field("tdata padding", {10'd0, want[31:30]},
                                  {10'd0, m_axis_tdata[31:30]}, 1'b0);
                end
            end
        end
        o_awaited = awaited_commands.size();
    end

endmodule

@@ test/testbench.sv @@
module testbench;
    import pfs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_FRAMES = 190;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int   mismatches;
    int   awaited;
    int   cycles;
    logic calm;
    int   cur_near;
    int   cur_far;

    proximity_follow_steering_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    steering_checker steer_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_awaited     (awaited)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        calm   = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_SPEED_LIMIT;
        i_cfg_data    <= '0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: stall now and then, never during the calm stretch
    always @(posedge i_clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);

    function automatic logic [IN_TDATA_W-1:0] pack_frame(input int s0, s1, s2, s3,
                                                        input int s4, s5, s6, s7);
        int                    v [SENSOR_COUNT];
        logic [IN_TDATA_W-1:0] f;
        v[0] = s0; v[1] = s1; v[2] = s2; v[3] = s3;
        v[4] = s4; v[5] = s5; v[6] = s6; v[7] = s7;
        f = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
            f[i*SENSOR_W +: SENSOR_W] = v[i][SENSOR_W-1:0];
        return f;
    endfunction

    // Mostly frames whose leader sits on a threshold, ties, or a front pair
    function automatic logic [IN_TDATA_W-1:0] random_frame();
        int v [SENSOR_COUNT];
        int kind;
        int top;
        int lead;
        kind = $urandom_range(0, 5);
        lead = $urandom_range(0, 7);
        case (kind)
            1:       top = $urandom_range(0, 8) - 4;
            2, 3:    top = ($urandom_range(0, 1) ? cur_near : cur_far) + $urandom_range(0, 2) - 1;
            4:       top = $urandom_range(0, 1) ? 4095 - $urandom_range(0, 2)
                                                : -4096 + $urandom_range(0, 3);
            default: top = $urandom_range(0, 8191) - 4096;
        endcase
        if (top > 4095)
            top = 4095;
        if (top < -4096)
            top = -4096;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (kind == 0)
                v[i] = $urandom_range(0, 8191) - 4096;
            else if (kind == 1)
                v[i] = $urandom_range(0, 8) - 4;
            else
                v[i] = $urandom_range(0, top + 4096) - 4096;
        end
        if (kind != 0) begin
            v[lead] = top;
            if ($urandom_range(0, 3) == 0) begin
                v[0] = top;
                v[7] = top - $urandom_range(0, 2);
                if (v[7] < -4096)
                    v[7] = -4096;
                if ($urandom_range(0, 1)) begin
                    v[7] = v[0];
                    v[0] = top - $urandom_range(0, 1);
                    if (v[0] < -4096)
                        v[0] = -4096;
                end
            end
        end
        return pack_frame(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endfunction

    task automatic send_frame(input logic [IN_TDATA_W-1:0] frame);
        if (!calm && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold the sender until every expected beat is back, then let the pipe settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (awaited != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_limits(input int limit, input int near, input int far);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SPEED_LIMIT;
        i_cfg_data  <= limit[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_NEAR_THRESHOLD;
        i_cfg_data  <= near[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_FAR_THRESHOLD;
        i_cfg_data  <= far[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_near = near;
        cur_far  = far;
    endtask

    task automatic random_frames(input int count);
        for (int n = 0; n < count; n++)
            send_frame(random_frame());
    endtask

    initial begin
        cur_near = RESET_NEAR_THRESHOLD;
        cur_far  = RESET_FAR_THRESHOLD;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits: 500, near 2500, far 2000
        send_frame(pack_frame(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
        send_frame(pack_frame(-4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096));
        send_frame(pack_frame(0, 0, 0, 0, 0, 0, 0, 0));
        send_frame(pack_frame(-2731, 2730, -2731, 2730, -2731, 2730, -2731, 2730));
        send_frame(pack_frame(2730, -2731, 2730, -2731, 2730, -2731, 2730, -2731));
        // both fronts lead: back off, stop, approach, exactly at near
        send_frame(pack_frame(3000, 10, 20, 30, 40, 50, 60, 2900));
        send_frame(pack_frame(2100, -5, -5, -5, -5, -5, -5, 2200));
        send_frame(pack_frame(1500, 0, 0, 0, 0, 0, 0, 1500));
        send_frame(pack_frame(2400, 0, 0, 0, 0, 0, 0, 2500));
        // one front leads
        send_frame(pack_frame(2000, -5, -5, -5, -5, -5, -5, -5));
        send_frame(pack_frame(-7, -8, -9, -10, -11, -12, -13, 3000));
        send_frame(pack_frame(-7, -8, -9, -10, -11, -12, -13, 1000));
        send_frame(pack_frame(3001, 100, 200, 3000, 0, 0, 0, 0));
        // side leaders around the far threshold
        send_frame(pack_frame(0, 2001, 0, 0, 0, 0, 0, 0));
        send_frame(pack_frame(0, 0, 1999, 0, 0, 0, 0, 0));
        send_frame(pack_frame(0, 0, 0, 2000, 0, 0, 0, 0));
        send_frame(pack_frame(0, 0, 0, 0, 4095, 0, 0, 0));
        send_frame(pack_frame(-9, -9, -9, -9, -9, -1, -9, -9));
        send_frame(pack_frame(-4096, -4096, -4096, -4096, -4096, -4096, -4095, -4096));
        // ties keep the earlier index; a later sensor can still take second place
        send_frame(pack_frame(0, 0, 100, 300, 0, 100, 0, 0));
        send_frame(pack_frame(0, 0, 0, 0, 700, 0, 700, 0));
        send_frame(pack_frame(10, 5, 8, 1, 1, 1, 1, 1));
        send_frame(pack_frame(-50, 50, -60, -60, -60, -60, -60, -60));

        random_frames(PHASE_FRAMES / 2);
        drain_results();
        random_frames(PHASE_FRAMES / 2);

        program_limits(0, 4095, 0);
        random_frames(PHASE_FRAMES);

        program_limits(1100, 0, 4095);
        random_frames(PHASE_FRAMES);

        // near below far, odd limit; no idling on either side here
        program_limits(1099, 1500, 3000);
        calm = 1'b1;
        random_frames(PHASE_FRAMES);
        calm = 1'b0;

        program_limits(1, 2000, 2000);
        random_frames(PHASE_FRAMES);

        program_limits(333, 3000, 1000);
        random_frames(PHASE_FRAMES);

        drain_results();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ proximity_follow_steering_unit.f @@
+incdir+rtl
rtl/pfs_pkg.sv
rtl/pfs_lane.sv
rtl/pfs_merge.sv
rtl/pfs_steer.sv
rtl/proximity_follow_steering_unit.sv
test/steering_checker.sv
test/testbench.sv
